@@ src/nsdr_pkg.sv @@
// Shared types, constants and helper functions of the noise-shaped requantizer.
package nsdr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W = $clog2(MAX_CHANNELS);
    localparam int TAPS = 16;
    localparam int TAP_W = $clog2(TAPS);
    localparam int HIST_W = 40;
    localparam int COEF_W = 16;
    localparam int FILT_W = 48;

    // configuration register indexes
    localparam logic [2:0] REG_BITS_KEPT = 3'd0;
    localparam logic [2:0] REG_SHAPING = 3'd1;
    localparam logic [2:0] REG_DITHER_EN = 3'd2;
    localparam logic [2:0] REG_OUT_FMT = 3'd3;
    localparam logic [2:0] REG_GAIN = 3'd4;

    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;

    localparam logic [7:0] RIGHT_TAPS = 8'hF5;
    localparam logic [7:0] LEFT_TAPS = 8'h63;

    typedef enum logic [1:0] {
        MODE_ROUND,
        MODE_RECT,
        MODE_SHAPE
    } t_mode;

    typedef struct packed {
        logic signed [31:0] x;
        logic [CH_W-1:0]    chan;
        logic [TAP_W-1:0]   ph;
        logic [5:0]         bits;
        logic [4:0]         s;
        t_mode              mode;
        logic [1:0]         fmt;
        logic [1:0]         set;
        logic [15:0]        g;
        logic signed [33:0] rsum;
        logic signed [31:0] lastr;
    } t_ctl;

    // Q3.12 error-feedback coefficients, one row per shaping strength
    localparam logic signed [COEF_W-1:0] COEF [4][TAPS] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd3482, 16'sd1192, -16'sd206, -16'sd964, -16'sd2391, -16'sd2746,
          -16'sd1580, -16'sd623, -16'sd106, 16'sd578, 16'sd917, 16'sd631,
          16'sd214, -16'sd12, -16'sd125, -16'sd127},
        '{16'sd7325, 16'sd3912, -16'sd756, -16'sd1810, -16'sd3621, -16'sd5825,
          -16'sd4179, -16'sd1428, -16'sd471, 16'sd512, 16'sd1559, 16'sd1306,
          16'sd430, -16'sd127, -16'sd264, -16'sd120},
        '{16'sd11840, 16'sd11015, 16'sd864, -16'sd4030, -16'sd4549, -16'sd8968,
          -16'sd9687, -16'sd3911, -16'sd980, -16'sd568, 16'sd1785, 16'sd2699,
          16'sd998, -16'sd10, 16'sd76, 16'sd71}
    };

    // shift right rounding toward zero
    function automatic logic signed [63:0] f_trunc_shr(input logic signed [63:0] v,
                                                       input logic [5:0] n);
        logic signed [63:0] m;
        m = v[63] ? ((64'sd1 <<< n) - 64'sd1) : 64'sd0;
        return (v + m) >>> n;
    endfunction

    function automatic logic signed [HIST_W-1:0] f_sat40(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = -(64'sd1 <<< (HIST_W - 1));
        hi = (64'sd1 <<< (HIST_W - 1)) - 64'sd1;
        if (v < lo) begin
            return lo[HIST_W-1:0];
        end else if (v > hi) begin
            return hi[HIST_W-1:0];
        end
        return v[HIST_W-1:0];
    endfunction

endpackage

@@ src/nsdr_if.sv @@
// Stream and configuration interfaces of the requantizer.
interface nsdr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_in;
    logic [2:0]         channel;
    modport source(output valid, sample_in, channel, input ready);
    modport sink(input valid, sample_in, channel, output ready);
endinterface

interface nsdr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_out;
    logic [2:0]         channel_out;
    modport source(output valid, sample_out, channel_out, input ready);
    modport sink(input valid, sample_out, channel_out, output ready);
endinterface

interface nsdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ src/nsdr_dither_gen.sv @@
// Twin parity polycounters producing one or two summed random words per step.
module nsdr_dither_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_twice,
    output logic signed [33:0] o_rsum
);
    import nsdr_pkg::*;

    logic [31:0] r_right, r_left;
    logic [31:0] right1, left1, right2, left2;
    logic [31:0] rnd1, rnd2;

    // left taps look at bits 25 and up; the mask's top bit lands past bit 31
    always_comb begin
        right1 = {^(r_right[7:0] & RIGHT_TAPS), r_right[31:1]};
        left1  = {r_left[30:0], ^({1'b0, r_left[31:25]} & LEFT_TAPS)};
        right2 = {^(right1[7:0] & RIGHT_TAPS), right1[31:1]};
        left2  = {left1[30:0], ^({1'b0, left1[31:25]} & LEFT_TAPS)};
        rnd1   = right1 ^ left1;
        rnd2   = right2 ^ left2;
        o_rsum = i_twice ? (34'($signed(rnd1)) + 34'($signed(rnd2)))
                         : 34'($signed(rnd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= 32'd1;
            r_left  <= 32'd1;
        end else if (i_step) begin
            r_right <= i_twice ? right2 : right1;
            r_left  <= i_twice ? left2 : left1;
        end
    end
endmodule

@@ src/nsdr_hist_mem.sv @@
// Per-channel dither and error history rows, one entry written per item.
module nsdr_hist_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [nsdr_pkg::CH_W-1:0]        i_rd_ch,
    output logic signed [nsdr_pkg::HIST_W-1:0] o_dh [nsdr_pkg::TAPS],
    output logic signed [nsdr_pkg::HIST_W-1:0] o_eh [nsdr_pkg::TAPS],
    input  logic                             i_wr_en,
    input  logic [nsdr_pkg::CH_W-1:0]        i_wr_ch,
    input  logic [nsdr_pkg::TAP_W-1:0]       i_wr_slot,
    input  logic signed [nsdr_pkg::HIST_W-1:0] i_wr_dh,
    input  logic signed [nsdr_pkg::HIST_W-1:0] i_wr_eh
);
    import nsdr_pkg::*;

    logic signed [HIST_W-1:0] mem_dh [MAX_CHANNELS][TAPS];
    logic signed [HIST_W-1:0] mem_eh [MAX_CHANNELS][TAPS];
    logic [TAPS-1:0]          r_vld [MAX_CHANNELS];
    logic signed [HIST_W-1:0] r_rd_dh [TAPS];
    logic signed [HIST_W-1:0] r_rd_eh [TAPS];
    logic [TAPS-1:0]          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_dh[i_wr_ch][i_wr_slot] <= i_wr_dh;
            mem_eh[i_wr_ch][i_wr_slot] <= i_wr_eh;
        end
        if (i_rd_en) begin
            r_rd_dh <= mem_dh[i_rd_ch];
            r_rd_eh <= mem_eh[i_rd_ch];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_vld[c] <= '0;
            end
            r_rd_vld <= '0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_ch][i_wr_slot] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_ch];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            o_dh[j] = r_rd_vld[j] ? r_rd_dh[j] : '0;
            o_eh[j] = r_rd_vld[j] ? r_rd_eh[j] : '0;
        end
    end
endmodule

@@ src/nsdr_filter.sv @@
// 16-tap rotating-phase FIR: product stage, two adder-tree stages, rounding.
module nsdr_filter (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [nsdr_pkg::HIST_W-1:0] i_row [nsdr_pkg::TAPS],
    input  logic [1:0]                         i_set,
    input  logic [nsdr_pkg::TAP_W-1:0]         i_ph,
    output logic signed [nsdr_pkg::FILT_W-1:0] o_res
);
    import nsdr_pkg::*;

    logic signed [55:0] r_prod [TAPS];
    logic signed [57:0] r_part [TAPS/4];
    logic signed [59:0] acc;

    always_comb begin
        acc = '0;
        for (int k = 0; k < TAPS/4; k++) begin
            acc = acc + 60'(r_part[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < TAPS; j++) begin
                r_prod[j] <= 56'(i_row[j] * COEF[i_set][TAP_W'(i_ph + TAP_W'(j))]);
            end
            for (int k = 0; k < TAPS/4; k++) begin
                r_part[k] <= 58'(r_prod[4*k]) + 58'(r_prod[4*k+1])
                           + 58'(r_prod[4*k+2]) + 58'(r_prod[4*k+3]);
            end
            o_res <= FILT_W'((acc + 60'sd2048) >>> 12);
        end
    end
endmodule

@@ src/noise_shaped_dither_requantizer.sv @@
// Noise-shaped dither requantizer: accepts one word per cycle while successive words
// belong to different channels and the output is not stalled; a word of a channel whose
// previous word has not yet written its history back waits, so the words of one channel
// alone never overlap in the pipeline. The per-channel history rows sit in a synchronous
// memory read on acceptance and written one entry back at the last stage; history entries
// read as zero until written after reset, with no clearing pass.
module noise_shaped_dither_requantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsdr_in_if.sink     i_in,
    nsdr_out_if.source  o_out,
    nsdr_cfg_if.sink    i_cfg
);
    import nsdr_pkg::*;

    logic [5:0]  r_bits_kept;
    logic [1:0]  r_shaping;
    logic        r_dither_en;
    logic [1:0]  r_out_fmt;
    logic [15:0] r_gain;

    logic [TAP_W-1:0]   r_tap [MAX_CHANNELS];
    logic signed [31:0] r_last [MAX_CHANNELS];

    t_ctl r_s1, r_s2, r_s3, r_s4, r_s5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_ov;
    logic signed [31:0] r_out;
    logic [CH_W-1:0]    r_out_ch;

    logic signed [50:0] r_gr;
    logic signed [33:0] r_tmp3, r_tmp4;
    logic signed [31:0] r_now3, r_now4, r_now5;
    logic signed [49:0] r_sum0;
    logic signed [HIST_W-1:0] r_d;
    logic signed [40:0] r_sum;
    logic signed [49:0] r_pre;

    logic adv, hazard, accept;
    logic [CH_W-1:0] in_ch;
    logic [5:0] bits;
    t_ctl n_s1;
    logic signed [33:0] rsum;
    logic signed [HIST_W-1:0] dh_row [TAPS];
    logic signed [HIST_W-1:0] eh_row [TAPS];
    logic signed [FILT_W-1:0] fd, fe;
    logic signed [63:0] add_q8, n_sum0, e, val1, valm, vsh, lim;
    logic signed [HIST_W-1:0] n_d, err;
    logic signed [40:0] n_sum;
    logic signed [49:0] n_pre;
    logic signed [31:0] n_out;
    logic wr_hist;

    assign in_ch  = i_in.channel;
    assign adv    = !r_ov || o_out.ready;
    assign hazard = (r_v1 && r_s1.chan == in_ch) || (r_v2 && r_s2.chan == in_ch)
                 || (r_v3 && r_s3.chan == in_ch) || (r_v4 && r_s4.chan == in_ch)
                 || (r_v5 && r_s5.chan == in_ch);
    assign i_in.ready  = adv && !hazard;
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign bits = (r_bits_kept < 6'd11) ? 6'd11 : ((r_bits_kept > 6'd32) ? 6'd32 : r_bits_kept);

    always_comb begin
        n_s1.x     = i_in.sample_in;
        n_s1.chan  = in_ch;
        n_s1.ph    = r_tap[in_ch];
        n_s1.bits  = bits;
        n_s1.s     = 5'(6'd32 - bits);
        n_s1.fmt   = r_out_fmt;
        n_s1.set   = r_shaping;
        n_s1.g     = r_gain;
        n_s1.rsum  = rsum;
        n_s1.lastr = r_last[in_ch];
        if (!r_dither_en) begin
            n_s1.mode = MODE_ROUND;
        end else if (r_shaping == 2'd0) begin
            n_s1.mode = MODE_RECT;
        end else begin
            n_s1.mode = MODE_SHAPE;
        end
    end

    nsdr_dither_gen u_dither (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept && r_dither_en),
        .i_twice (r_shaping != 2'd0),
        .o_rsum  (rsum)
    );

    assign wr_hist = adv && r_v5 && r_s5.mode == MODE_SHAPE;

    nsdr_hist_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv),
        .i_rd_ch   (in_ch),
        .o_dh      (dh_row),
        .o_eh      (eh_row),
        .i_wr_en   (wr_hist),
        .i_wr_ch   (r_s5.chan),
        .i_wr_slot (TAP_W'(4'd15 - r_s5.ph)),
        .i_wr_dh   (r_d),
        .i_wr_eh   (err)
    );

    nsdr_filter u_fdith (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_row (dh_row),
        .i_set (r_s1.set),
        .i_ph  (r_s1.ph),
        .o_res (fd)
    );

    nsdr_filter u_ferr (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_row (eh_row),
        .i_set (r_s1.set),
        .i_ph  (r_s1.ph),
        .o_res (fe)
    );

    // stage 4 -> 5: dither sample, shaped sum and pre-rounding value; also the stage 3 -> 4 rectangular sum
    always_comb begin
        add_q8 = ((64'sd1 <<< r_s4.s) - 64'sd1) <<< 7;
        n_sum0 = (64'(r_s3.x) <<< 8) + 64'(r_tmp3) - (64'(r_s3.lastr) <<< 8);
        n_d    = f_sat40(64'(r_tmp4) - 64'(fd));
        n_sum  = 41'((64'(r_s4.x) <<< 8) + 64'(n_d));
        e      = 64'(n_sum) + 64'(fe);
        case (r_s4.mode)
            MODE_ROUND: n_pre = 50'((64'(r_s4.x) <<< 8) + add_q8);
            MODE_RECT:  n_pre = 50'(64'(r_sum0) + add_q8);
            default:    n_pre = 50'(e + add_q8);
        endcase
    end

    // stage 5 -> output: round, mask, error term, format and saturate
    always_comb begin
        val1 = f_trunc_shr(64'(r_pre), 6'd8);
        valm = (r_s5.mode == MODE_ROUND) ? val1 : ((val1 >>> r_s5.s) <<< r_s5.s);
        err  = f_sat40(64'(r_sum) - (valm <<< 8));
        case (r_s5.fmt)
            FMT_16: begin
                vsh = valm >>> 16;
                lim = 64'sd1 <<< 15;
            end
            FMT_24: begin
                vsh = valm >>> 8;
                lim = 64'sd1 <<< 23;
            end
            default: begin
                vsh = valm;
                lim = 64'sd1 <<< 31;
            end
        endcase
        if (vsh < -lim) begin
            n_out = 32'(-lim);
        end else if (vsh > lim - 64'sd1) begin
            n_out = 32'(lim - 64'sd1);
        end else begin
            n_out = 32'(vsh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1   <= n_s1;
            r_s2   <= r_s1;
            r_s3   <= r_s2;
            r_s4   <= r_s3;
            r_s5   <= r_s4;
            r_gr   <= 51'($signed({1'b0, r_s1.g}) * r_s1.rsum);
            r_tmp3 <= 34'(r_gr >>> (6'd8 + r_s2.bits));
            r_now3 <= 32'(f_trunc_shr(64'(r_gr), 6'd16 + r_s2.bits));
            r_tmp4 <= r_tmp3;
            r_now4 <= r_now3;
            r_sum0 <= 50'(n_sum0);
            r_now5 <= r_now4;
            r_d    <= n_d;
            r_sum  <= n_sum;
            r_pre  <= n_pre;
            r_out    <= n_out;
            r_out_ch <= r_s5.chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
            r_bits_kept <= 6'd16;
            r_shaping   <= 2'd0;
            r_dither_en <= 1'b1;
            r_out_fmt   <= 2'd0;
            r_gain      <= 16'd51118;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_tap[c]  <= '0;
                r_last[c] <= '0;
            end
        end else begin
            if (adv) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
                r_ov <= r_v5;
            end
            if (accept) begin
                r_tap[in_ch] <= TAP_W'(r_tap[in_ch] + 1'b1);
            end
            if (adv && r_v5 && r_s5.mode == MODE_RECT) begin
                r_last[r_s5.chan] <= r_now5;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_BITS_KEPT: r_bits_kept <= i_cfg.data[5:0];
                    REG_SHAPING:   r_shaping   <= i_cfg.data[1:0];
                    REG_DITHER_EN: r_dither_en <= i_cfg.data[0];
                    REG_OUT_FMT:   r_out_fmt   <= i_cfg.data[1:0];
                    REG_GAIN:      r_gain      <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.sample_out  = r_out;
    assign o_out.channel_out = r_out_ch;

`ifndef NO_ASSERTIONS
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && adv |=> o_out.valid)
        else $error("last stage word did not reach output register");
    a_no_dup_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v5 |-> r_s1.chan != r_s5.chan)
        else $error("same channel twice in flight");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif
endmodule
